// File: rtl/grid_astar_path_search_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid path search unit
// Implication checks on the block clock with reset masking.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define GAPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GAPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Types, codes and helpers shared by the grid path search unit.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int CELL_W = 6;
  localparam int COST_W = 7;
  localparam int CNT_W  = 7;
  localparam int OPEN_W = COST_W + CELL_W;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [1:0] DIR_COL_INC = 2'd0;
  localparam logic [1:0] DIR_ROW_INC = 2'd1;
  localparam logic [1:0] DIR_COL_DEC = 2'd2;
  localparam logic [1:0] DIR_ROW_DEC = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_SCAN_RD, ST_SCAN_CMP, ST_POP_RD, ST_POP_WR, ST_G_RD, ST_G_LD,
    ST_NB_CHK, ST_NB_WALL, ST_LS_RD, ST_LS_CMP, ST_LS_GRD, ST_LS_GCMP, ST_ADD,
    ST_NB_NEXT, ST_PATH_PUSH, ST_PATH_RD, ST_PATH_NX, ST_EMIT_RD, ST_EMIT_LD,
    ST_EMIT_OUT, ST_NOPATH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_INIT, OP_SCAN_RD, OP_SCAN_CMP, OP_POP_RD, OP_POP_WR,
    OP_G_RD, OP_G_LD, OP_NB_CHK, OP_NB_WALL, OP_LS_RD, OP_LS_NEXT, OP_LS_GRD,
    OP_UPDATE, OP_ADD, OP_NB_NEXT, OP_PUSH, OP_PATH_RD, OP_PATH_NX, OP_EMIT_RD,
    OP_EMIT_LD, OP_EMIT_NEXT, OP_NOPATH_LD
  } op_t;

  typedef struct packed {
    logic wr_item;
    logic in_grid;
    logic scan_end;
    logic is_goal;
    logic nb_out;
    logic blocked;
    logic nb_last;
    logic open_empty;
    logic ls_end;
    logic ls_hit;
    logic improve;
    logic room;
    logic path_done;
    logic emit_last;
  } stat_t;

  typedef struct packed {
    logic       func;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       blocked;
    logic [2:0] start_row;
    logic [2:0] start_col;
    logic [2:0] goal_row;
    logic [2:0] goal_col;
  } in_item_t;

  function automatic logic [3:0] manhattan(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
    logic [2:0] dr;
    logic [2:0] dc;
    dr = (a[5:3] > b[5:3]) ? 3'(a[5:3] - b[5:3]) : 3'(b[5:3] - a[5:3]);
    dc = (a[2:0] > b[2:0]) ? 3'(a[2:0] - b[2:0]) : 3'(b[2:0] - a[2:0]);
    return {1'b0, dr} + {1'b0, dc};
  endfunction

endpackage

// File: rtl/gaps_in_if.sv
// ----------------------------------------------------------------------------
// gaps_in_if
// Input item channel: write or search item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gaps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] cell_row;
  logic [2:0] cell_col;
  logic       blocked;
  logic [2:0] start_row;
  logic [2:0] start_col;
  logic [2:0] goal_row;
  logic [2:0] goal_col;

  modport source (output valid, func, cell_row, cell_col, blocked, start_row, start_col,
                  goal_row, goal_col, input ready);
  modport sink (input valid, func, cell_row, cell_col, blocked, start_row, start_col,
                goal_row, goal_col, output ready);
endinterface

// File: rtl/gaps_out_if.sv
// ----------------------------------------------------------------------------
// gaps_out_if
// Result item channel: one path cell or the no-path item.
// ----------------------------------------------------------------------------
interface gaps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] path_row;
  logic [2:0] path_col;
  logic       found;
  logic       last;

  modport source (output valid, path_row, path_col, found, last, input ready);
  modport sink (input valid, path_row, path_col, found, last, output ready);
endinterface

// File: rtl/gaps_ctrl.sv
// ----------------------------------------------------------------------------
// gaps_ctrl
// Search sequencer: accepts items and steps the datapath through scan, pop, expand, trace and emit.
// ----------------------------------------------------------------------------
module gaps_ctrl import gaps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t st,
  output op_t   op,
  output logic  in_ready,
  output logic  out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !st.wr_item) begin
          state_nxt = st.in_grid ? ST_INIT : ST_NOPATH;
        end
      end
      ST_INIT:     state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = st.scan_end ? ST_POP_RD : ST_SCAN_RD;
      ST_POP_RD:   state_nxt = ST_POP_WR;
      ST_POP_WR:   state_nxt = st.is_goal ? ST_PATH_PUSH : ST_G_RD;
      ST_G_RD:     state_nxt = ST_G_LD;
      ST_G_LD:     state_nxt = ST_NB_CHK;
      ST_NB_CHK:   state_nxt = st.nb_out ? ST_NB_NEXT : ST_NB_WALL;
      ST_NB_WALL:  state_nxt = st.blocked ? ST_NB_NEXT : ST_LS_RD;
      ST_LS_RD:    state_nxt = st.ls_end ? ST_ADD : ST_LS_CMP;
      ST_LS_CMP:   state_nxt = st.ls_hit ? ST_LS_GRD : ST_LS_RD;
      ST_LS_GRD:   state_nxt = ST_LS_GCMP;
      ST_LS_GCMP:  state_nxt = ST_NB_NEXT;
      ST_ADD:      state_nxt = ST_NB_NEXT;
      ST_NB_NEXT: begin
        if (!st.nb_last) begin
          state_nxt = ST_NB_CHK;
        end else begin
          state_nxt = st.open_empty ? ST_NOPATH : ST_SCAN_RD;
        end
      end
      ST_PATH_PUSH: state_nxt = st.path_done ? ST_EMIT_RD : ST_PATH_RD;
      ST_PATH_RD:   state_nxt = ST_PATH_NX;
      ST_PATH_NX:   state_nxt = ST_PATH_PUSH;
      ST_EMIT_RD:   state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:   state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_ready) begin
          state_nxt = st.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_NOPATH:    state_nxt = ST_EMIT_OUT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op        = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_ACCEPT;
        end
      end
      ST_INIT:      op = OP_INIT;
      ST_SCAN_RD:   op = OP_SCAN_RD;
      ST_SCAN_CMP:  op = OP_SCAN_CMP;
      ST_POP_RD:    op = OP_POP_RD;
      ST_POP_WR:    op = OP_POP_WR;
      ST_G_RD:      op = OP_G_RD;
      ST_G_LD:      op = OP_G_LD;
      ST_NB_CHK:    op = OP_NB_CHK;
      ST_NB_WALL:   op = OP_NB_WALL;
      ST_LS_RD:     op = OP_LS_RD;
      ST_LS_CMP:    op = st.ls_hit ? OP_NONE : OP_LS_NEXT;
      ST_LS_GRD:    op = OP_LS_GRD;
      ST_LS_GCMP:   op = st.improve ? OP_UPDATE : OP_NONE;
      ST_ADD:       op = st.room ? OP_ADD : OP_NONE;
      ST_NB_NEXT:   op = OP_NB_NEXT;
      ST_PATH_PUSH: op = OP_PUSH;
      ST_PATH_RD:   op = OP_PATH_RD;
      ST_PATH_NX:   op = OP_PATH_NX;
      ST_EMIT_RD:   op = OP_EMIT_RD;
      ST_EMIT_LD:   op = OP_EMIT_LD;
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op = OP_EMIT_NEXT;
        end
      end
      ST_NOPATH:    op = OP_NOPATH_LD;
      default:      op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/gaps_dp.sv
// ----------------------------------------------------------------------------
// gaps_dp
// Search datapath: grid, open list, cost and parent stores, path stack.
// ----------------------------------------------------------------------------
module gaps_dp import gaps_pkg::*; #(
  parameter int GRID_SIDE = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        op,
  input  in_item_t   in_item,
  output stat_t      st,
  output logic [2:0] out_row,
  output logic [2:0] out_col,
  output logic       out_found,
  output logic       out_last
);

  localparam logic [3:0]       SIDE  = 4'(GRID_SIDE);
  localparam logic [CNT_W-1:0] CELLS = CNT_W'(GRID_SIDE * GRID_SIDE);

  logic              wall_mem [64];
  logic [63:0]       wall_vld_r;
  logic              wall_rd_r;
  logic [OPEN_W-1:0] open_mem [64];
  logic [OPEN_W-1:0] open_rd_r;
  logic [COST_W-1:0] g_mem [64];
  logic [COST_W-1:0] g_rd_r;
  logic [CELL_W-1:0] from_mem [64];
  logic [CELL_W-1:0] from_rd_r;
  logic [CELL_W-1:0] stack_mem [64];
  logic [CELL_W-1:0] stack_rd_r;

  logic [63:0]       closed_r;
  logic [CELL_W-1:0] start_r, goal_r, best_cell_r, cur_r, n_r, p_r;
  logic [5:0]        best_idx_r;
  logic [COST_W-1:0] best_f_r, gcur_r, ng_r, nf_r;
  logic [CNT_W-1:0]  i_r, count_r, j_r, len_r, k_r;
  logic [1:0]        d_r;
  logic [2:0]        out_row_r, out_col_r;
  logic              out_found_r, out_last_r;

  logic [CELL_W-1:0] wall_wa;
  logic              wall_we;
  logic [CELL_W-1:0] open_wa, open_ra;
  logic [OPEN_W-1:0] open_wd;
  logic              open_we;
  logic [CELL_W-1:0] g_wa, g_ra;
  logic [COST_W-1:0] g_wd;
  logic              g_we;
  logic [CELL_W-1:0] from_wa, from_wd;
  logic              from_we;
  logic [CELL_W-1:0] stack_ra;
  logic [CELL_W-1:0] nb_key;
  logic              nb_out;
  logic [COST_W-1:0] ng_c, nf_c;
  logic [CNT_W-1:0]  emit_idx;

  assign wall_wa = {in_item.cell_row, in_item.cell_col};
  assign wall_we = (op == OP_ACCEPT) && (in_item.func == FUNC_WRITE) &&
                   ({1'b0, in_item.cell_row} < SIDE) && ({1'b0, in_item.cell_col} < SIDE);

  always_comb begin
    nb_key = cur_r;
    nb_out = 1'b0;
    unique case (d_r)
      DIR_COL_INC: begin
        nb_out = ({1'b0, cur_r[2:0]} + 4'd1) >= SIDE;
        nb_key = {cur_r[5:3], 3'(cur_r[2:0] + 3'd1)};
      end
      DIR_ROW_INC: begin
        nb_out = ({1'b0, cur_r[5:3]} + 4'd1) >= SIDE;
        nb_key = {3'(cur_r[5:3] + 3'd1), cur_r[2:0]};
      end
      DIR_COL_DEC: begin
        nb_out = cur_r[2:0] == 3'd0;
        nb_key = {cur_r[5:3], 3'(cur_r[2:0] - 3'd1)};
      end
      DIR_ROW_DEC: begin
        nb_out = cur_r[5:3] == 3'd0;
        nb_key = {3'(cur_r[5:3] - 3'd1), cur_r[2:0]};
      end
      default: begin
        nb_out = 1'b1;
      end
    endcase
  end

  assign ng_c     = COST_W'(gcur_r + 7'd1);
  assign nf_c     = COST_W'(ng_c + {3'd0, manhattan(n_r, goal_r)});
  assign emit_idx = CNT_W'(len_r - 7'd1 - k_r);

  always_comb begin
    open_we = 1'b0;
    open_wa = '0;
    open_wd = '0;
    g_we    = 1'b0;
    g_wa    = n_r;
    g_wd    = ng_r;
    from_we = 1'b0;
    from_wa = n_r;
    from_wd = cur_r;
    unique case (op)
      OP_INIT: begin
        open_we = 1'b1;
        open_wd = {3'd0, manhattan(start_r, goal_r), start_r};
        g_we    = 1'b1;
        g_wa    = start_r;
        g_wd    = '0;
        from_we = 1'b1;
        from_wa = start_r;
        from_wd = start_r;
      end
      OP_POP_WR: begin
        open_we = 1'b1;
        open_wa = best_idx_r;
        open_wd = open_rd_r;
      end
      OP_UPDATE, OP_ADD: begin
        open_we = 1'b1;
        open_wa = (op == OP_ADD) ? count_r[5:0] : j_r[5:0];
        open_wd = {nf_r, n_r};
        g_we    = 1'b1;
        from_we = 1'b1;
      end
      default: begin
        open_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (op)
      OP_POP_RD: open_ra = 6'(count_r - 7'd1);
      OP_LS_RD:  open_ra = j_r[5:0];
      default:   open_ra = i_r[5:0];
    endcase
  end

  assign g_ra     = (op == OP_G_RD) ? cur_r : n_r;
  assign stack_ra = emit_idx[5:0];

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= in_item.blocked;
    end
    wall_rd_r <= wall_mem[nb_key] & wall_vld_r[nb_key];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_vld_r <= '0;
    end else if (wall_we) begin
      wall_vld_r[wall_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (open_we) begin
      open_mem[open_wa] <= open_wd;
    end
    open_rd_r <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      g_mem[g_wa] <= g_wd;
    end
    g_rd_r <= g_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (from_we) begin
      from_mem[from_wa] <= from_wd;
    end
    from_rd_r <= from_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (op == OP_PUSH) begin
      stack_mem[len_r[5:0]] <= p_r;
    end
    stack_rd_r <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      closed_r <= '0;
    end else begin
      unique case (op)
        OP_INIT:   begin
          count_r  <= CNT_W'(1);
          closed_r <= '0;
        end
        OP_POP_WR: count_r <= CNT_W'(count_r - 7'd1);
        OP_ADD:    count_r <= CNT_W'(count_r + 7'd1);
        OP_G_RD:   closed_r[cur_r] <= 1'b1;
        default:   count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        start_r <= {in_item.start_row, in_item.start_col};
        goal_r  <= {in_item.goal_row, in_item.goal_col};
      end
      OP_INIT: i_r <= '0;
      OP_SCAN_CMP: begin
        if ((i_r == '0) || (open_rd_r[OPEN_W-1:CELL_W] < best_f_r)) begin
          best_idx_r  <= i_r[5:0];
          best_f_r    <= open_rd_r[OPEN_W-1:CELL_W];
          best_cell_r <= open_rd_r[CELL_W-1:0];
        end
        i_r <= CNT_W'(i_r + 7'd1);
      end
      OP_POP_WR: begin
        cur_r <= best_cell_r;
        p_r   <= goal_r;
        len_r <= '0;
      end
      OP_G_LD: begin
        gcur_r <= g_rd_r;
        d_r    <= DIR_COL_INC;
      end
      OP_NB_CHK: n_r <= nb_key;
      OP_NB_WALL: begin
        ng_r <= ng_c;
        nf_r <= nf_c;
        j_r  <= '0;
      end
      OP_LS_NEXT: j_r <= CNT_W'(j_r + 7'd1);
      OP_NB_NEXT: begin
        d_r <= 2'(d_r + 2'd1);
        i_r <= '0;
      end
      OP_PUSH: begin
        len_r <= CNT_W'(len_r + 7'd1);
        k_r   <= '0;
      end
      OP_PATH_NX: p_r <= from_rd_r;
      OP_EMIT_LD: begin
        out_row_r   <= stack_rd_r[5:3];
        out_col_r   <= stack_rd_r[2:0];
        out_found_r <= 1'b1;
        out_last_r  <= CNT_W'(k_r + 7'd1) == len_r;
      end
      OP_EMIT_NEXT: k_r <= CNT_W'(k_r + 7'd1);
      OP_NOPATH_LD: begin
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_found_r <= 1'b0;
        out_last_r  <= 1'b1;
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  assign st.wr_item    = in_item.func == FUNC_WRITE;
  assign st.in_grid    = ({1'b0, in_item.start_row} < SIDE) &&
                         ({1'b0, in_item.start_col} < SIDE) &&
                         ({1'b0, in_item.goal_row} < SIDE) &&
                         ({1'b0, in_item.goal_col} < SIDE);
  assign st.scan_end   = CNT_W'(i_r + 7'd1) == count_r;
  assign st.is_goal    = best_cell_r == goal_r;
  assign st.nb_out     = nb_out;
  assign st.blocked    = wall_rd_r | closed_r[n_r];
  assign st.nb_last    = d_r == DIR_ROW_DEC;
  assign st.open_empty = count_r == '0;
  assign st.ls_end     = j_r == count_r;
  assign st.ls_hit     = open_rd_r[CELL_W-1:0] == n_r;
  assign st.improve    = g_rd_r > ng_r;
  assign st.room       = count_r < CELLS;
  assign st.path_done  = (p_r == start_r) || (CNT_W'(len_r + 7'd1) >= CELLS);
  assign st.emit_last  = out_last_r;

  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_found = out_found_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/grid_astar_path_search_unit.sv
// Write item: accepted, no result.
// Search: each pop scans the open list with a read and a compare per entry; each
// free neighbour searches the list again with a read and a compare per entry,
// then each path cell is traced (push, read, next) and emitted (read, load,
// output), plus output stalls. One item at a time. Reset clears the sequencer,
// open count, closed marks and the wall valid bits.
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// A* search on a square grid with wall writes and path cell results.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_unit_defines.svh"

module grid_astar_path_search_unit import gaps_pkg::*; #(
  parameter int GRID_SIDE = 8
) (
  input logic      clk,
  input logic      rst_n,
  gaps_in_if.sink  in_ch,
  gaps_out_if.source out_ch
);

  op_t      op;
  stat_t    st;
  in_item_t in_item;

  assign in_item = '{func: in_ch.func, cell_row: in_ch.cell_row, cell_col: in_ch.cell_col,
                     blocked: in_ch.blocked, start_row: in_ch.start_row,
                     start_col: in_ch.start_col, goal_row: in_ch.goal_row,
                     goal_col: in_ch.goal_col};

  gaps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .op        (op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  gaps_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_item   (in_item),
    .st        (st),
    .out_row   (out_ch.path_row),
    .out_col   (out_ch.path_col),
    .out_found (out_ch.found),
    .out_last  (out_ch.last)
  );

  `GAPS_ASSERT_IMP(a_no_overlap, out_ch.valid, !in_ch.ready)
  `GAPS_ASSERT_NXT(a_idle_after_last, out_ch.valid && out_ch.ready && out_ch.last, in_ch.ready)
  `GAPS_ASSERT_IMP(a_nopath_is_last, out_ch.valid && !out_ch.found, out_ch.last)

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid path search unit. A directed table and a
// random run drive wall writes and searches in bursts while the result side
// stalls. An in-bench A* model or a typed table row predicts each path cell, checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import gaps_pkg::*;

  localparam int SIDE      = 8;
  localparam int NCELLS    = SIDE * SIDE;
  localparam int CYCLE_CAP = 20000000;
  localparam int N_RANDOM  = 117;

  typedef struct {
    logic [2:0] row;
    logic [2:0] col;
    logic       found;
    logic       last;
  } path_cell_t;

  typedef struct {
    in_item_t   item;
    bit         typed;
    path_cell_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   cycle_cnt;
  int   err_cnt;

  gaps_in_if  in_ch ();
  gaps_out_if out_ch ();

  grid_astar_path_search_unit #(.GRID_SIDE(SIDE)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  path_cell_t path_q[$];

  logic       wall_map[NCELLS];
  bit         closed[NCELLS];
  logic [5:0] open_list[NCELLS];
  int         open_cnt;
  int         g_cost[NCELLS];
  int         f_cost[NCELLS];
  logic [5:0] parent[NCELLS];
  logic [5:0] trail[NCELLS];

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("grid_astar_path_search_unit regression: fail");
      $finish;
    end
  end

  function automatic int grid_dist(int r1, int c1, int r2, int c2);
    return ((r1 > r2) ? r1 - r2 : r2 - r1) + ((c1 > c2) ? c1 - c2 : c2 - c1);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  task automatic push_cell(int row, int col, bit fnd, bit lst);
    path_cell_t c;
    c.row   = 3'(row);
    c.col   = 3'(col);
    c.found = fnd;
    c.last  = lst;
    path_q.push_back(c);
  endtask

  // Walls update the map; searches run A* and queue the path cells.
  task automatic predict_path(in_item_t it);
    int  step_r[4];
    int  step_c[4];
    int  start_c, goal_c, best, cur, cr, cc, nr, nc, nb, ng, len, p;
    bit  reached, listed;
    step_r = '{0, 1, 0, -1};
    step_c = '{1, 0, -1, 0};
    if (it.func == FUNC_WRITE) begin
      wall_map[{it.cell_row, it.cell_col}] = it.blocked;
      return;
    end
    start_c = {it.start_row, it.start_col};
    goal_c  = {it.goal_row, it.goal_col};
    foreach (closed[i]) closed[i] = 0;
    g_cost[start_c] = 0;
    f_cost[start_c] = grid_dist(it.start_row, it.start_col, it.goal_row, it.goal_col);
    parent[start_c] = 6'(start_c);
    open_list[0] = 6'(start_c);
    open_cnt = 1;
    reached = 0;
    while (open_cnt > 0 && !reached) begin
      best = 0;
      for (int i = 1; i < open_cnt; i++)
        if (f_cost[open_list[i]] < f_cost[open_list[best]]) best = i;
      cur = open_list[best];
      open_cnt--;
      open_list[best] = open_list[open_cnt];
      if (cur == goal_c) begin
        len = 0;
        p = goal_c;
        forever begin
          trail[len] = 6'(p);
          len++;
          if (p == start_c || len >= NCELLS) break;
          p = parent[p];
        end
        for (int k = 0; k < len; k++)
          push_cell(trail[len-1-k] / SIDE, trail[len-1-k] % SIDE, 1, k + 1 == len);
        reached = 1;
      end else begin
        closed[cur] = 1;
        cr = cur / SIDE;
        cc = cur % SIDE;
        for (int d = 0; d < 4; d++) begin
          nr = cr + step_r[d];
          nc = cc + step_c[d];
          if (nr < 0 || nr >= SIDE || nc < 0 || nc >= SIDE) continue;
          nb = nr * SIDE + nc;
          if (wall_map[nb] || closed[nb]) continue;
          ng = g_cost[cur] + 1;
          listed = 0;
          for (int j = 0; j < open_cnt; j++) begin
            if (open_list[j] == nb) begin
              if (g_cost[nb] > ng) begin
                g_cost[nb] = ng;
                f_cost[nb] = ng + grid_dist(nr, nc, it.goal_row, it.goal_col);
                parent[nb] = 6'(cur);
              end
              listed = 1;
              break;
            end
          end
          if (!listed && open_cnt < NCELLS) begin
            g_cost[nb] = ng;
            f_cost[nb] = ng + grid_dist(nr, nc, it.goal_row, it.goal_col);
            parent[nb] = 6'(cur);
            open_list[open_cnt] = 6'(nb);
            open_cnt++;
          end
        end
      end
    end
    if (!reached) push_cell(0, 0, 0, 1);
  endtask

  // Hold the item until accepted, then queue what it should produce.
  task automatic send_item(in_item_t it, bit typed, path_cell_t want);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= it.func;
    in_ch.cell_row  <= it.cell_row;
    in_ch.cell_col  <= it.cell_col;
    in_ch.blocked   <= it.blocked;
    in_ch.start_row <= it.start_row;
    in_ch.start_col <= it.start_col;
    in_ch.goal_row  <= it.goal_row;
    in_ch.goal_col  <= it.goal_col;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      path_q.push_back(want);
    end else begin
      predict_path(it);
    end
  endtask

  task automatic burst_gap(inout int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 6);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t wall_item(int r, int c, bit b);
    in_item_t it;
    it          = in_item_t'($urandom);
    it.func     = FUNC_WRITE;
    it.cell_row = 3'(r);
    it.cell_col = 3'(c);
    it.blocked  = b;
    return it;
  endfunction

  function automatic in_item_t search_item(int sr, int sc, int gr, int gc);
    in_item_t it;
    it           = in_item_t'($urandom);
    it.func      = FUNC_SEARCH;
    it.start_row = 3'(sr);
    it.start_col = 3'(sc);
    it.goal_row  = 3'(gr);
    it.goal_col  = 3'(gc);
    return it;
  endfunction

  function automatic stim_row_t mk_row(in_item_t it, bit typed, int r, int c, bit f);
    stim_row_t s;
    s.item       = it;
    s.typed      = typed;
    s.want.row   = 3'(r);
    s.want.col   = 3'(c);
    s.want.found = f;
    s.want.last  = 1'b1;
    return s;
  endfunction

  always @(posedge clk) begin
    path_cell_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (path_q.size() == 0) begin
        report("unexpected item", out_ch.path_row, 0);
      end else begin
        w = path_q.pop_front();
        if (out_ch.path_row !== w.row)   report("path_row", out_ch.path_row, w.row);
        if (out_ch.path_col !== w.col)   report("path_col", out_ch.path_col, w.col);
        if (out_ch.found !== w.found)    report("found", out_ch.found, w.found);
        if (out_ch.last !== w.last)      report("last", out_ch.last, w.last);
      end
    end
    if (cycle_cnt[10])
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    else if (cycle_cnt[9])
      out_ch.ready <= ($urandom_range(0, 9) == 0);
    else
      out_ch.ready <= 1'b1;
  end

  initial begin
    stim_row_t  table_rows[$];
    path_cell_t none;
    int         burst_left;
    int         wait_cnt;
    int         pick;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cycle_cnt    = 0;
    err_cnt      = 0;
    burst_left   = 0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_WRITE;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    in_ch.blocked   = 1'b0;
    in_ch.start_row = '0;
    in_ch.start_col = '0;
    in_ch.goal_row  = '0;
    in_ch.goal_col  = '0;
    out_ch.ready = 1'b1;
    foreach (wall_map[i]) wall_map[i] = 1'b0;
    none = '{3'd0, 3'd0, 1'b0, 1'b0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    table_rows.push_back(mk_row(search_item(0, 0, 0, 0), 1, 0, 0, 1));
    table_rows.push_back(mk_row(search_item(7, 7, 7, 7), 1, 7, 7, 1));
    table_rows.push_back(mk_row(search_item(0, 0, 7, 7), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(7, 7, 0, 0), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(3, 4, 3, 5), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(7, 7, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(0, 0, 7, 7), 1, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(7, 7, 7, 7), 1, 7, 7, 1));
    table_rows.push_back(mk_row(wall_item(0, 0, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(0, 0, 0, 2), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(0, 6, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(1, 7, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(2, 2, 0, 7), 1, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(0, 7, 2, 2), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(3, 1, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(3, 2, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(3, 3, 1), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(1, 2, 5, 2), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(0, 6, 0), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(1, 7, 0), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(7, 7, 0), 0, 0, 0, 0));
    table_rows.push_back(mk_row(wall_item(0, 0, 0), 0, 0, 0, 0));
    table_rows.push_back(mk_row(search_item(7, 0, 0, 7), 0, 0, 0, 0));

    foreach (table_rows[i]) begin
      burst_gap(burst_left);
      send_item(table_rows[i].item, table_rows[i].typed, table_rows[i].want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      burst_gap(burst_left);
      pick = $urandom_range(0, 9);
      if (pick < 6)
        send_item(wall_item($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 3) == 0), 0, none);
      else
        send_item(search_item($urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom_range(0, 7)), 0, none);
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (path_q.size() != 0 && wait_cnt < CYCLE_CAP) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);

    if (err_cnt == 0 && path_q.size() == 0)
      $display("grid_astar_path_search_unit regression: pass");
    else
      $display("grid_astar_path_search_unit regression: fail");
    $finish;
  end

endmodule

// File: grid_astar_path_search_unit.f
+incdir+rtl
rtl/gaps_pkg.sv
rtl/gaps_in_if.sv
rtl/gaps_out_if.sv
rtl/gaps_ctrl.sv
rtl/gaps_dp.sv
rtl/grid_astar_path_search_unit.sv
test/tb_top.sv
